// File: rtl/ps2s1_pkg.sv
// ----------------------------------------------------------------------------
// ps2s1_pkg: shared types and tables for the set 1 scancode translator
// key kinds, navigation codes, scancode constants and the US layout tables
// ----------------------------------------------------------------------------
package ps2s1_pkg;

   // scancode constants
   localparam logic [7:0] SC_PREFIX  = 8'hE0;
   localparam logic [6:0] SC_LSHIFT  = 7'h2A;
   localparam logic [6:0] SC_RSHIFT  = 7'h36;
   localparam logic [6:0] SC_CTRL    = 7'h1D;
   localparam logic [6:0] SC_ALT     = 7'h38;
   localparam logic [6:0] SC_CAPS    = 7'h3A;
   localparam logic [6:0] SC_PGUP    = 7'h49;
   localparam logic [6:0] SC_PGDN    = 7'h51;
   localparam logic [6:0] SC_ENTER   = 7'h1C;
   localparam logic [6:0] ASCII_CR   = 7'h0D;
   localparam logic [6:0] CASE_BIT   = 7'h20;
   localparam logic [6:0] CTRL_MASK  = 7'h1F;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_NAV  = 2'd2
   } key_kind_type;

   typedef enum logic [1:0] {
      SCROLL_NONE = 2'd0,
      SCROLL_UP   = 2'd1,
      SCROLL_DOWN = 2'd2
   } scroll_type;

   typedef enum logic [3:0] {
      NAV_UP    = 4'd0,
      NAV_DOWN  = 4'd1,
      NAV_LEFT  = 4'd2,
      NAV_RIGHT = 4'd3,
      NAV_HOME  = 4'd4,
      NAV_END   = 4'd5,
      NAV_PGUP  = 4'd6,
      NAV_PGDN  = 4'd7,
      NAV_INS   = 4'd8,
      NAV_DEL   = 4'd9
   } nav_key_type;

   // modifier and prefix state
   typedef struct packed {
      logic shift;
      logic ctrl;
      logic alt;
      logic caps;
      logic prefix;
   } flags_type;

   // one result word
   typedef struct packed {
      key_kind_type key_kind;
      logic [6:0]   char_code;
      nav_key_type  nav_key;
      scroll_type   scroll_request;
      logic         shift_held;
      logic         ctrl_held;
      logic         alt_held;
      logic         caps_on;
   } result_type;

   // unshifted layout, zero for unmapped codes
   function automatic logic [6:0] plain_char(input logic [6:0] idx);
      logic [6:0] c;
      case (idx)
         7'h01: c = 7'h1B;  7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;
         7'h05: c = 7'h34;  7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;
         7'h09: c = 7'h38;  7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;
         7'h0D: c = 7'h3D;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h71;
         7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;  7'h14: c = 7'h74;
         7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;  7'h18: c = 7'h6F;
         7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;  7'h1C: c = 7'h0D;
         7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
         7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
         7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;
         7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;
         7'h2F: c = 7'h76;  7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;
         7'h33: c = 7'h2C;  7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;
         7'h39: c = 7'h20;  7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;
         7'h4A: c = 7'h2D;  7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;
         7'h4E: c = 7'h2B;  7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;
         7'h52: c = 7'h30;  7'h53: c = 7'h2E;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   // shifted layout, falls back to the plain table where both agree
   function automatic logic [6:0] shift_char(input logic [6:0] idx);
      logic [6:0] c;
      case (idx)
         7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
         7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
         7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
         7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
         7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
         7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
         7'h1E: c = 7'h41;  7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;
         7'h22: c = 7'h47;  7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;
         7'h26: c = 7'h4C;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h29: c = 7'h7E;
         7'h2B: c = 7'h7C;  7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;
         7'h2F: c = 7'h56;  7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;
         7'h33: c = 7'h3C;  7'h34: c = 7'h3E;  7'h35: c = 7'h3F;
         default: c = plain_char(idx);
      endcase
      return c;
   endfunction

endpackage

// File: rtl/ps2s1_in_reg.sv
// ----------------------------------------------------------------------------
// ps2s1_in_reg: input register
// holds one scancode word until the translate stage takes it
// ----------------------------------------------------------------------------
module ps2s1_in_reg
   import ps2s1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scancode,
   input  logic       take,        // translate stage consumes the held word
   output logic       held_valid,
   output logic [7:0] held_code
);

   logic       valid_ff, valid_in;
   logic [7:0] code_ff, code_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         code_in  = req_scancode;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
   end

   assign held_valid = valid_ff;
   assign held_code  = code_ff;

endmodule

// File: rtl/ps2s1_xlate.sv
// ----------------------------------------------------------------------------
// ps2s1_xlate: scancode translation and modifier state
// one pass of decode and table lookup, flags advance on each consumed word
// ----------------------------------------------------------------------------
module ps2s1_xlate
   import ps2s1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] code,
   output result_type result
);

   flags_type  flags_ff, flags_in;
   logic [6:0] mk;
   logic [6:0] lut;
   logic [6:0] ch;
   logic       is_lower, is_upper;

   assign mk = code[6:0];

   always_comb begin
      lut      = flags_ff.shift ? shift_char(mk) : plain_char(mk);
      ch       = lut;
      is_lower = (lut >= 7'h61) && (lut <= 7'h7A);
      is_upper = (lut >= 7'h41) && (lut <= 7'h5A);
      // caps flips letter case once
      if (flags_ff.caps && (is_lower || is_upper)) begin
         ch = lut ^ CASE_BIT;
      end
      // ctrl maps letters to 1..26
      if (flags_ff.ctrl && (is_lower || is_upper)) begin
         ch = ch & CTRL_MASK;
      end
   end

   always_comb begin
      flags_in = flags_ff;
      result   = '{key_kind: KIND_NONE, char_code: 7'h00, nav_key: NAV_UP,
                   scroll_request: SCROLL_NONE, shift_held: 1'b0,
                   ctrl_held: 1'b0, alt_held: 1'b0, caps_on: 1'b0};
      if (code == SC_PREFIX) begin
         flags_in.prefix = 1'b1;
      end else if (code[7]) begin
         // release code
         if (mk == SC_LSHIFT || mk == SC_RSHIFT) flags_in.shift = 1'b0;
         if (mk == SC_CTRL) flags_in.ctrl = 1'b0;
         if (mk == SC_ALT) flags_in.alt = 1'b0;
         flags_in.prefix = 1'b0;
      end else if (flags_ff.prefix) begin
         flags_in.prefix = 1'b0;
         result.key_kind = KIND_NAV;
         unique case (mk)
            7'h48:   result.nav_key = NAV_UP;
            7'h50:   result.nav_key = NAV_DOWN;
            7'h4B:   result.nav_key = NAV_LEFT;
            7'h4D:   result.nav_key = NAV_RIGHT;
            7'h47:   result.nav_key = NAV_HOME;
            7'h4F:   result.nav_key = NAV_END;
            7'h49:   result.nav_key = NAV_PGUP;
            7'h51:   result.nav_key = NAV_PGDN;
            7'h52:   result.nav_key = NAV_INS;
            7'h53:   result.nav_key = NAV_DEL;
            SC_ENTER: begin
               result.key_kind  = KIND_CHAR;
               result.char_code = ASCII_CR;
            end
            default: result.key_kind = KIND_NONE;
         endcase
      end else if (mk == SC_LSHIFT || mk == SC_RSHIFT) begin
         flags_in.shift = 1'b1;
      end else if (mk == SC_CTRL) begin
         flags_in.ctrl = 1'b1;
      end else if (mk == SC_ALT) begin
         flags_in.alt = 1'b1;
      end else if (mk == SC_CAPS) begin
         flags_in.caps = !flags_ff.caps;
      end else if (flags_ff.shift && mk == SC_PGUP) begin
         result.scroll_request = SCROLL_UP;
      end else if (flags_ff.shift && mk == SC_PGDN) begin
         result.scroll_request = SCROLL_DOWN;
      end else if (lut != 7'h00) begin
         result.key_kind  = KIND_CHAR;
         result.char_code = ch;
      end
      result.shift_held = flags_in.shift;
      result.ctrl_held  = flags_in.ctrl;
      result.alt_held   = flags_in.alt;
      result.caps_on    = flags_in.caps;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (step) begin
         flags_ff <= flags_in;
      end
   end

   // flags only move when a word is consumed
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(flags_ff))
      else $error("flags changed without a consumed word");

   // prefix byte arms the extended flag
   a_prefix_set: assert property (@(posedge clock) disable iff (reset)
      step && code == SC_PREFIX |=> flags_ff.prefix)
      else $error("prefix flag not set after prefix byte");

   // shift release always drops shift
   a_shift_rel: assert property (@(posedge clock) disable iff (reset)
      step && code[7] && (mk == SC_LSHIFT || mk == SC_RSHIFT) |=> !flags_ff.shift)
      else $error("shift still held after release");

   // a word with a key never also asks for a scroll
   a_kind_scroll: assert property (@(posedge clock) disable iff (reset)
      result.key_kind != KIND_NONE |-> result.scroll_request == SCROLL_NONE)
      else $error("key and scroll request in one word");

endmodule

// File: rtl/ps2s1_out_reg.sv
// ----------------------------------------------------------------------------
// ps2s1_out_reg: result register
// holds one translated word until the consumer takes it
// ----------------------------------------------------------------------------
module ps2s1_out_reg
   import ps2s1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   output logic       load_ready,
   input  result_type load_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_word
);

   logic       valid_ff, valid_in;
   result_type word_ff, word_in;

   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         word_in  = load_word;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: rtl/ps2s1_set1_scancode_to_ascii_top.sv
// ----------------------------------------------------------------------------
// ps2_set1_scancode_to_ascii_top: PS/2 set 1 scancode to ASCII translator
// US QWERTY layout with shift, ctrl, alt, caps lock and extended key tracking
// ----------------------------------------------------------------------------
// each scancode byte written on the req channel gives exactly one word on the
// rsp channel, in order; an accepted byte is held in the input register,
// where the translate logic works on it, and is then loaded into the result
// register once that register has room, which raises rsp_valid; one byte can
// be accepted every cycle while the consumer keeps up, and when rsp_ready
// stays low the full result register holds the input register, which then
// drops req_ready, so throughput is set by rsp_ready alone
// ----------------------------------------------------------------------------
module ps2_set1_scancode_to_ascii_top
   import ps2s1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // scancode input
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scancode,
   // translated key output
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_key_kind,
   output logic [6:0] rsp_char_code,
   output logic [3:0] rsp_nav_key,
   output logic [1:0] rsp_scroll_request,
   output logic       rsp_shift_held,
   output logic       rsp_ctrl_held,
   output logic       rsp_alt_held,
   output logic       rsp_caps_on
);

   logic       held_valid;
   logic [7:0] held_code;
   logic       load_ready;
   logic       step;          // held byte moves into the result register
   result_type xlate_word;
   result_type out_word;

   // byte moves on when the result register has room
   assign step = held_valid && load_ready;

   ps2s1_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_scancode (req_scancode),
      .take         (step),
      .held_valid   (held_valid),
      .held_code    (held_code)
   );

   // modifier flags live here and advance with each step
   ps2s1_xlate u_xlate (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .code   (held_code),
      .result (xlate_word)
   );

   ps2s1_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (held_valid),
      .load_ready (load_ready),
      .load_word  (xlate_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (out_word)
   );

   // unpack the result word onto the ports
   assign rsp_key_kind       = out_word.key_kind;
   assign rsp_char_code      = out_word.char_code;
   assign rsp_nav_key        = out_word.nav_key;
   assign rsp_scroll_request = out_word.scroll_request;
   assign rsp_shift_held     = out_word.shift_held;
   assign rsp_ctrl_held      = out_word.ctrl_held;
   assign rsp_alt_held       = out_word.alt_held;
   assign rsp_caps_on        = out_word.caps_on;

endmodule
